>>> src/brld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brld_pkg;

  localparam int BYTE_W   = 8;
  localparam int PRB_W    = 9;
  localparam int PLANE_W  = 4;
  localparam int ROW_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_ROW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_PRESENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED    = 3'd4;

  localparam logic [BYTE_W-1:0] CTRL_NOP = 8'd128;
  localparam logic [8:0]        RUN_BASE = 9'd257;

  localparam logic [BYTE_W-1:0]  RST_BYTES_PER_ROW = 8'd40;
  localparam logic [PLANE_W-1:0] RST_PLANE_COUNT   = 4'd5;
  localparam logic [ROW_W-1:0]   RST_ROW_COUNT     = 12'd256;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } brld_phase_t;

  typedef struct packed {
    brld_phase_t        phase;
    logic [BYTE_W-1:0]  literal_left;
    logic [PRB_W-1:0]   plane_row_bytes;
    logic [PLANE_W-1:0] plane_index;
    logic [ROW_W-1:0]   row_index;
    logic               finished;
  } brld_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  bytes_per_row;
    logic [PLANE_W-1:0] plane_count;
    logic [ROW_W-1:0]   row_count;
    logic               mask_present;
    logic               compressed;
  } brld_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] pixel_byte;
    logic [BYTE_W-1:0] repeat_count;
    logic              image_end;
  } brld_result_t;

endpackage

`default_nettype wire

>>> src/bitplane_run_length_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Run-length body decoder for interleaved bitplane images. Each result (a
// byte with a repeat count, or an end marker) is in the output register on
// the next cycle. Control, no-op and mask plane bytes give no result, bar the
// end marker on the last byte. The rate is one byte per cycle, bounded only
// by the single state update each byte makes on the phase and row/plane
// counters; a request is held off only while the output register is full and
// stalled. After the final row, bytes are taken and dropped until reset.
// Configuration must be written only while idle; the core does not check it.
module bitplane_run_length_decoder_core
  import brld_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire [BYTE_W-1:0]      in_body_byte,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [BYTE_W-1:0]     out_pixel_byte,
  output logic [BYTE_W-1:0]     out_repeat_count,
  output logic                  out_image_end
);

  brld_cfg_t    cfg_r;
  brld_state_t  state_r;
  brld_state_t  state_nxt;
  brld_result_t res;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BYTE_W-1:0] pixel_r;
  logic [BYTE_W-1:0] repeat_r;
  logic              end_r;
  logic              in_acc;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  brld_step u_step (
    .cfg       (cfg_r),
    .cur       (state_r),
    .body_byte (in_body_byte),
    .nxt       (state_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes_per_row <= RST_BYTES_PER_ROW;
      cfg_r.plane_count   <= RST_PLANE_COUNT;
      cfg_r.row_count     <= RST_ROW_COUNT;
      cfg_r.mask_present  <= 1'b0;
      cfg_r.compressed    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BYTES_PER_ROW: cfg_r.bytes_per_row <= cfg_data[BYTE_W-1:0];
        CFG_PLANE_COUNT:   cfg_r.plane_count   <= cfg_data[PLANE_W-1:0];
        CFG_ROW_COUNT:     cfg_r.row_count     <= cfg_data[ROW_W-1:0];
        CFG_MASK_PRESENT:  cfg_r.mask_present  <= cfg_data[0];
        CFG_COMPRESSED:    cfg_r.compressed    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_CONTROL, literal_left: '0, plane_row_bytes: '0,
                   plane_index: '0, row_index: '0, finished: 1'b0};
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = res.valid;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.valid) begin
      pixel_r  <= res.pixel_byte;
      repeat_r <= res.repeat_count;
      end_r    <= res.image_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_byte   = pixel_r;
  assign out_repeat_count = repeat_r;
  assign out_image_end    = end_r;

`ifndef SYNTHESIS
  a_end_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && end_r |-> state_r.finished)
    else $error("image end shown without finished state");

  a_quiet_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.finished && !(out_valid_r && out_stall) |=> !out_valid_r)
    else $error("result produced after image finished");

  a_literal_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_LITERAL |-> state_r.literal_left != '0)
    else $error("literal phase with no bytes left");

  a_repeat_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_REPEAT |-> state_r.literal_left >= 8'd2)
    else $error("repeat phase with bad run length");

  a_marker_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (repeat_r == 8'd0) |-> end_r)
    else $error("zero repeat count on a data result");
`endif

endmodule

`default_nettype wire

>>> src/brld_step.sv
`timescale 1ns / 1ps
`default_nettype none

module brld_step
  import brld_pkg::*;
(
  input  wire brld_cfg_t     cfg,
  input  wire brld_state_t   cur,
  input  wire [BYTE_W-1:0]   body_byte,
  output brld_state_t        nxt,
  output brld_result_t       res
);

  logic [BYTE_W-1:0]  bpr;
  logic [PLANE_W-1:0] planes;
  logic [ROW_W-1:0]   rows;

  // zero-valued limits behave as one
  assign bpr    = (cfg.bytes_per_row == '0) ? 8'd1 : cfg.bytes_per_row;
  assign planes = (cfg.plane_count == '0) ? 4'd1 : cfg.plane_count;
  assign rows   = (cfg.row_count == '0) ? 12'd1 : cfg.row_count;

  always_comb begin
    logic              data;
    logic              in_mask;
    logic              do_close;
    logic              emit;
    logic              end_flag;
    logic [PRB_W-1:0]  prb_sum;
    logic [BYTE_W-1:0] n;
    logic [ROW_W-1:0]  row_inc;

    nxt      = cur;
    data     = cur.plane_index < planes;
    in_mask  = ~data;
    do_close = 1'b0;
    emit     = 1'b0;
    end_flag = 1'b0;
    prb_sum  = cur.plane_row_bytes;
    n        = 8'd1;
    row_inc  = cur.row_index + 12'd1;

    if (!cur.finished) begin
      if (!cfg.compressed) begin
        nxt.phase = PH_CONTROL;
        prb_sum   = cur.plane_row_bytes + 9'd1;
        do_close  = 1'b1;
        emit      = 1'b1;
      end else begin
        unique case (cur.phase)
          PH_LITERAL: begin
            prb_sum          = cur.plane_row_bytes + 9'd1;
            nxt.literal_left = cur.literal_left - 8'd1;
            emit             = 1'b1;
            if (cur.literal_left == 8'd1) begin
              nxt.phase = PH_CONTROL;
              do_close  = 1'b1;
            end
          end
          PH_REPEAT: begin
            prb_sum          = cur.plane_row_bytes + {1'b0, cur.literal_left};
            n                = cur.literal_left;
            nxt.literal_left = '0;
            nxt.phase        = PH_CONTROL;
            do_close         = 1'b1;
            emit             = 1'b1;
          end
          default: begin
            nxt.phase = PH_CONTROL;
            if (body_byte < CTRL_NOP) begin
              nxt.literal_left = body_byte + 8'd1;
              nxt.phase        = PH_LITERAL;
            end else if (body_byte > CTRL_NOP) begin
              nxt.literal_left = BYTE_W'(RUN_BASE - {1'b0, body_byte});
              nxt.phase        = PH_REPEAT;
            end
          end
        endcase
      end
    end

    nxt.plane_row_bytes = prb_sum;

    // end of a plane row: step to next plane, the mask plane, or next image row
    if (do_close && (prb_sum >= {1'b0, bpr})) begin
      nxt.plane_row_bytes = '0;
      if (!in_mask && (({1'b0, cur.plane_index} + 5'd1) < {1'b0, planes})) begin
        nxt.plane_index = cur.plane_index + 4'd1;
      end else if (!in_mask && cfg.mask_present) begin
        nxt.plane_index = planes;
      end else begin
        nxt.plane_index = '0;
        nxt.row_index   = row_inc;
        if ((row_inc >= rows) || (row_inc == '0)) begin
          nxt.finished = 1'b1;
          end_flag     = 1'b1;
        end
      end
    end

    res.valid        = emit && (data || end_flag);
    res.pixel_byte   = data ? body_byte : 8'd0;
    res.repeat_count = data ? n : 8'd0;
    res.image_end    = end_flag;
  end

endmodule

`default_nettype wire
